### sv/improved_gradient_noise_3d_assert.svh
// ----------------------------------------------------------------------------
// improved gradient noise assertion macros
// concurrent assertion forms shared by the checker
// ----------------------------------------------------------------------------
`ifndef IMPROVED_GRADIENT_NOISE_3D_ASSERT_SVH
`define IMPROVED_GRADIENT_NOISE_3D_ASSERT_SVH

// same-cycle implication
`define IGN_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IGN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ign_pkg.sv
// ----------------------------------------------------------------------------
// ign_pkg
// shared types and constants of the improved gradient noise block
// ----------------------------------------------------------------------------
`default_nettype none

package ign_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int TAB_AW     = 8;
  localparam int CELL_W     = 8;
  localparam int COORD_W    = 32;
  localparam int FREQ_W     = 24;
  localparam int AMP_W      = 16;
  localparam int OCT_W      = 4;
  localparam int FUNC_W     = 2;
  localparam int OUT_W      = 32;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;
  localparam int N_SLOTS    = 14;
  localparam int N_LERPS    = 7;
  localparam int IDX_W      = 4;

  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EVAL3D = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EVAL1D = 2'd2;

  localparam logic [1:0] REG_FREQUENCY = 2'd0;
  localparam logic [1:0] REG_AMPLITUDE = 2'd1;
  localparam logic [1:0] REG_OCTAVES   = 2'd2;

  localparam logic [FREQ_W-1:0] FREQ_RESET = 24'd65536;
  localparam logic [AMP_W-1:0]  AMP_RESET  = 16'd256;
  localparam logic [OCT_W-1:0]  OCT_RESET  = 4'd1;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_SPLIT,
    OP_FADE1,
    OP_FADE2,
    OP_FADE3,
    OP_FADE4,
    OP_READ,
    OP_LATCH,
    OP_DIFF,
    OP_LERP,
    OP_AMP,
    OP_ACC,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency;
    logic [AMP_W-1:0]  amplitude;
    logic [OCT_W-1:0]  octave_count;
  } cfg_t;

endpackage

`default_nettype wire

### sv/ign_ram.sv
// ----------------------------------------------------------------------------
// ign_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ign_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### sv/ign_cfg.sv
// ----------------------------------------------------------------------------
// ign_cfg
// apb register bank for frequency, amplitude and octave count
// ----------------------------------------------------------------------------
`default_nettype none

module ign_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ign_pkg::CFG_AW-1:0] paddr,
  input  logic [ign_pkg::CFG_DW-1:0] pwdata,
  output logic [ign_pkg::CFG_DW-1:0] prdata,
  output logic                      pready,
  output ign_pkg::cfg_t             cfg
);

  import ign_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (paddr[3:2])
        REG_FREQUENCY: cfg_nxt.frequency    = pwdata[FREQ_W-1:0];
        REG_AMPLITUDE: cfg_nxt.amplitude    = pwdata[AMP_W-1:0];
        REG_OCTAVES:   cfg_nxt.octave_count = pwdata[OCT_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frequency    <= FREQ_RESET;
      cfg_r.amplitude    <= AMP_RESET;
      cfg_r.octave_count <= OCT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FREQUENCY: prdata = CFG_DW'(cfg_r.frequency);
      REG_AMPLITUDE: prdata = CFG_DW'(cfg_r.amplitude);
      REG_OCTAVES:   prdata = CFG_DW'(cfg_r.octave_count);
      default:       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### sv/ign_ctrl.sv
// ----------------------------------------------------------------------------
// ign_ctrl
// sequencer stepping the datapath through split, fade, hash, diff, lerp, scale, accumulate, output
// ----------------------------------------------------------------------------
`default_nettype none

module ign_ctrl #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ign_pkg::FUNC_W-1:0] func,
  input  logic [ign_pkg::OCT_W-1:0]  octave_count,
  output logic                       busy,
  output logic                       accept,
  output ign_pkg::cmd_t              cmd
);

  import ign_pkg::*;

  localparam int OLW = $clog2(MAX_OCTAVES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SPLIT, S_FADE1, S_FADE2, S_FADE3, S_FADE4, S_READ, S_LATCH,
    S_DIFF, S_LERP, S_AMP, S_ACC, S_OUT
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] idx_r;
  logic [OLW-1:0]   oct_left_r;
  logic [OLW-1:0]   n_oct;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && (state_r == S_IDLE);

  always_comb begin
    if (octave_count > MAX_OCTAVES) begin
      n_oct = OLW'(MAX_OCTAVES);
    end else begin
      n_oct = OLW'(octave_count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      idx_r      <= '0;
      oct_left_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          idx_r <= '0;
          if (accept) begin
            if (func == FUNC_EVAL3D) begin
              oct_left_r <= OLW'(1);
              state_r    <= S_SPLIT;
            end else if (func == FUNC_EVAL1D) begin
              oct_left_r <= n_oct;
              state_r    <= (n_oct == '0) ? S_OUT : S_SPLIT;
            end
          end
        end
        S_SPLIT: begin
          if (idx_r == IDX_W'(2)) begin
            idx_r   <= '0;
            state_r <= S_FADE1;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_FADE1: state_r <= S_FADE2;
        S_FADE2: state_r <= S_FADE3;
        S_FADE3: state_r <= S_FADE4;
        S_FADE4: begin
          if (idx_r == IDX_W'(2)) begin
            idx_r   <= '0;
            state_r <= S_READ;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_FADE1;
          end
        end
        S_READ: state_r <= S_LATCH;
        S_LATCH: begin
          if (idx_r == IDX_W'(N_SLOTS - 1)) begin
            idx_r   <= '0;
            state_r <= S_DIFF;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_READ;
          end
        end
        S_DIFF: state_r <= S_LERP;
        S_LERP: begin
          if (idx_r == IDX_W'(N_LERPS - 1)) begin
            idx_r   <= '0;
            state_r <= S_AMP;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_DIFF;
          end
        end
        S_AMP: state_r <= S_ACC;
        S_ACC: begin
          if (oct_left_r == OLW'(1)) begin
            state_r <= S_OUT;
          end else begin
            oct_left_r <= oct_left_r - 1'b1;
            state_r    <= S_SPLIT;
          end
        end
        S_OUT:   state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.idx = idx_r;
    unique case (state_r)
      S_SPLIT: cmd.op = OP_SPLIT;
      S_FADE1: cmd.op = OP_FADE1;
      S_FADE2: cmd.op = OP_FADE2;
      S_FADE3: cmd.op = OP_FADE3;
      S_FADE4: cmd.op = OP_FADE4;
      S_READ:  cmd.op = OP_READ;
      S_LATCH: cmd.op = OP_LATCH;
      S_DIFF:  cmd.op = OP_DIFF;
      S_LERP:  cmd.op = OP_LERP;
      S_AMP:   cmd.op = OP_AMP;
      S_ACC:   cmd.op = OP_ACC;
      S_OUT:   cmd.op = OP_OUT;
      default: cmd.op = OP_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### sv/ign_dp.sv
// ----------------------------------------------------------------------------
// ign_dp
// noise datapath: shared multiplier, permutation ram, gradient and lerp regs
// ----------------------------------------------------------------------------
`default_nettype none

module ign_dp #(
  parameter int FRAC_BITS   = 16,
  parameter int MAX_OCTAVES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  ign_pkg::cmd_t                     cmd,
  input  ign_pkg::cfg_t                     cfg,
  input  logic [ign_pkg::FUNC_W-1:0]        in_func,
  input  logic signed [ign_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [ign_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [ign_pkg::COORD_W-1:0] in_coord_z,
  input  logic [ign_pkg::TAB_AW-1:0]        in_perm_index,
  input  logic [ign_pkg::CELL_W-1:0]        in_perm_value,
  output logic                              out_valid,
  output logic signed [ign_pkg::OUT_W-1:0]  out_noise_value
);

  import ign_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int LW  = F + 4;
  localparam int FW  = F + 1;
  localparam int CW  = F + 4;
  localparam int MW  = 33;
  localparam int PW  = 2 * MW;
  localparam int ACW = 36;
  localparam int SHW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

  localparam logic signed [LW-1:0]  ONE_L  = LW'(1) << F;
  localparam logic [CW-1:0]         FIFT_C = CW'(15) << F;
  localparam logic [CW-1:0]         TEN_C  = CW'(10) << F;
  localparam logic signed [ACW-1:0] SAT_HI = {{(ACW - 31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACW-1:0] SAT_LO = {{(ACW - 31){1'b1}}, {31{1'b0}}};

  logic signed [COORD_W-1:0] coord_r [3];
  logic [SHW-1:0]            sh_r;
  logic [CELL_W-1:0]         cell_r [3];
  logic [F-1:0]              frac_r [3];
  logic [FW-1:0]             fade_r [3];
  logic [CW-1:0]             c_r;
  logic [F-1:0]              t2_r;
  logic [F-1:0]              t3_r;
  logic [CELL_W-1:0]         slot_r [N_SLOTS];
  logic signed [LW-1:0]      a_r;
  logic signed [LW-1:0]      d_r;
  logic signed [LW-1:0]      lv_r [N_LERPS];
  logic signed [ACW-1:0]     amp_r;
  logic signed [ACW-1:0]     acc_r;
  logic                      out_valid_r;
  logic signed [OUT_W-1:0]   out_value_r;

  logic [1:0]              axis;
  logic [2:0]              lk;
  logic [F-1:0]            t;
  logic [CW-1:0]           six_t;
  logic [FW-1:0]           weight;
  logic signed [MW-1:0]    ma;
  logic signed [MW-1:0]    mb;
  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    q;
  logic signed [LW-1:0]    xv [2];
  logic signed [LW-1:0]    yv [2];
  logic signed [LW-1:0]    zv [2];
  logic signed [LW-1:0]    g [8];
  logic signed [LW-1:0]    la;
  logic signed [LW-1:0]    lb;
  logic [TAB_AW-1:0]       raddr;
  logic [CELL_W-1:0]       rdata;
  logic                    we;

  function automatic logic signed [LW-1:0] grad_f(
    input logic [3:0]           h,
    input logic signed [LW-1:0] x,
    input logic signed [LW-1:0] y,
    input logic signed [LW-1:0] z
  );
    logic signed [LW-1:0] u;
    logic signed [LW-1:0] v;
    u = (h < 4'd8) ? x : y;
    v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    grad_f = (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  assign axis  = cmd.idx[1:0];
  assign lk    = cmd.idx[2:0];
  assign t     = frac_r[axis];
  assign six_t = CW'({t, 2'b00}) + CW'({t, 1'b0});
  assign we    = accept && (in_func == FUNC_LOAD);

  ign_ram #(
    .WIDTH(CELL_W),
    .DEPTH(TABLE_SIZE)
  ) u_perm (
    .clk  (clk),
    .we   (we),
    .waddr(in_perm_index),
    .wdata(in_perm_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    if (lk < 3'd4) begin
      weight = fade_r[0];
    end else if (lk < 3'd6) begin
      weight = fade_r[1];
    end else begin
      weight = fade_r[2];
    end
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_SPLIT: begin
        ma = MW'(coord_r[axis]);
        mb = MW'(cfg.frequency);
      end
      OP_FADE1: begin
        ma = MW'(t);
        mb = MW'(FIFT_C - six_t);
      end
      OP_FADE2: begin
        ma = MW'(t);
        mb = MW'(t);
      end
      OP_FADE3: begin
        ma = MW'(t2_r);
        mb = MW'(t);
      end
      OP_FADE4: begin
        ma = MW'(t3_r);
        mb = MW'(TEN_C - c_r);
      end
      OP_LERP: begin
        ma = MW'(weight);
        mb = MW'(d_r);
      end
      OP_AMP: begin
        ma = MW'(lv_r[N_LERPS - 1]);
        mb = MW'(cfg.amplitude);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;
  assign q    = prod >>> sh_r;

  // corner gradients, corner bit 0 selects x-1, bit 1 y-1, bit 2 z-1
  always_comb begin
    xv[0] = $signed({{(LW - F){1'b0}}, frac_r[0]});
    yv[0] = $signed({{(LW - F){1'b0}}, frac_r[1]});
    zv[0] = $signed({{(LW - F){1'b0}}, frac_r[2]});
    xv[1] = xv[0] - ONE_L;
    yv[1] = yv[0] - ONE_L;
    zv[1] = zv[0] - ONE_L;
    for (int j = 0; j < 8; j++) begin
      g[j] = grad_f(slot_r[6 + j][3:0], xv[j % 2], yv[(j / 2) % 2], zv[j / 4]);
    end
  end

  always_comb begin
    case (lk)
      3'd4: begin
        la = lv_r[0];
        lb = lv_r[1];
      end
      3'd5: begin
        la = lv_r[2];
        lb = lv_r[3];
      end
      3'd6: begin
        la = lv_r[4];
        lb = lv_r[5];
      end
      default: begin
        la = g[{lk[1:0], 1'b0}];
        lb = g[{lk[1:0], 1'b1}];
      end
    endcase
  end

  // hash chain addresses
  always_comb begin
    case (cmd.idx)
      4'd0:    raddr = cell_r[0];
      4'd1:    raddr = cell_r[0] + 1'b1;
      4'd2:    raddr = slot_r[0] + cell_r[1];
      4'd3:    raddr = slot_r[0] + cell_r[1] + 1'b1;
      4'd4:    raddr = slot_r[1] + cell_r[1];
      4'd5:    raddr = slot_r[1] + cell_r[1] + 1'b1;
      4'd6:    raddr = slot_r[2] + cell_r[2];
      4'd7:    raddr = slot_r[4] + cell_r[2];
      4'd8:    raddr = slot_r[3] + cell_r[2];
      4'd9:    raddr = slot_r[5] + cell_r[2];
      4'd10:   raddr = slot_r[2] + cell_r[2] + 1'b1;
      4'd11:   raddr = slot_r[4] + cell_r[2] + 1'b1;
      4'd12:   raddr = slot_r[3] + cell_r[2] + 1'b1;
      4'd13:   raddr = slot_r[5] + cell_r[2] + 1'b1;
      default: raddr = cell_r[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      coord_r[0] <= in_coord_x;
      coord_r[1] <= (in_func == FUNC_EVAL1D) ? '0 : in_coord_y;
      coord_r[2] <= (in_func == FUNC_EVAL1D) ? '0 : in_coord_z;
      sh_r       <= '0;
      acc_r      <= '0;
    end
    case (cmd.op)
      OP_SPLIT: begin
        cell_r[axis] <= q[32 +: CELL_W];
        frac_r[axis] <= q[32 - F +: F];
      end
      OP_FADE1: c_r          <= prod[F +: CW];
      OP_FADE2: t2_r         <= prod[F +: F];
      OP_FADE3: t3_r         <= prod[F +: F];
      OP_FADE4: fade_r[axis] <= prod[F +: FW];
      OP_LATCH: slot_r[cmd.idx] <= rdata;
      OP_DIFF: begin
        a_r <= la;
        d_r <= lb - la;
      end
      OP_LERP: lv_r[lk] <= a_r + $signed(prod[F +: LW]);
      OP_AMP:  amp_r    <= $signed(prod[(F - 8) +: ACW]);
      OP_ACC: begin
        acc_r <= acc_r + amp_r;
        sh_r  <= sh_r + 1'b1;
      end
      OP_OUT: begin
        if (acc_r > SAT_HI) begin
          out_value_r <= SAT_HI[OUT_W-1:0];
        end else if (acc_r < SAT_LO) begin
          out_value_r <= SAT_LO[OUT_W-1:0];
        end else begin
          out_value_r <= acc_r[OUT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == OP_OUT);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_value_r;

endmodule

`default_nettype wire

### sv/improved_gradient_noise_3d.sv
// 3d evaluation: a result strobe per request; the next one can be taken in the strobe cycle
// 1d evaluation: sum of n octaves, n capped at MAX_OCTAVES; with n zero the result is zero
// one octave is 59 steps of one shared multiplier and one permutation ram read port
// table load: taken while idle, busy stays low, no result
// synchronous active-low reset clears control and config; the permutation table is not cleared
`default_nettype none

module improved_gradient_noise_3d #(
  parameter int FRAC_BITS   = 16,
  parameter int MAX_OCTAVES = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [ign_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [ign_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [ign_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [ign_pkg::COORD_W-1:0] in_coord_z,
  input  logic [ign_pkg::TAB_AW-1:0]         in_perm_index,
  input  logic [ign_pkg::CELL_W-1:0]         in_perm_value,
  output logic                               out_valid,
  output logic signed [ign_pkg::OUT_W-1:0]   out_noise_value,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ign_pkg::CFG_AW-1:0]         paddr,
  input  logic [ign_pkg::CFG_DW-1:0]         pwdata,
  output logic [ign_pkg::CFG_DW-1:0]         prdata,
  output logic                               pready
);

  import ign_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  logic accept;

  ign_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  ign_ctrl #(
    .MAX_OCTAVES(MAX_OCTAVES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .func        (in_func),
    .octave_count(cfg.octave_count),
    .busy        (busy),
    .accept      (accept),
    .cmd         (cmd)
  );

  ign_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_OCTAVES(MAX_OCTAVES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .cmd            (cmd),
    .cfg            (cfg),
    .in_func        (in_func),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .in_perm_index  (in_perm_index),
    .in_perm_value  (in_perm_value),
    .out_valid      (out_valid),
    .out_noise_value(out_noise_value)
  );

endmodule

`default_nettype wire

### sv/ign_checker.sv
// ----------------------------------------------------------------------------
// ign_checker
// port-level checks of request, result and config port timing, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "improved_gradient_noise_3d_assert.svh"

module ign_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [ign_pkg::FUNC_W-1:0] in_func,
  input logic                       out_valid,
  input logic                       psel,
  input logic                       pready
);

  import ign_pkg::*;

  `IGN_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe lasted two cycles")
  `IGN_ASSERT_SAME(a_strobe_idle, out_valid, !busy, "result shown while still busy")
  `IGN_ASSERT_NEXT(a_load_quick, start && !busy && in_func == FUNC_LOAD, !busy && !out_valid, "load request made the block busy")
  `IGN_ASSERT_NEXT(a_eval_busy, start && !busy && in_func == FUNC_EVAL3D, busy, "3d request not started")
  `IGN_ASSERT_SAME(a_pready, psel, pready, "config port stalled")

endmodule

bind improved_gradient_noise_3d ign_checker u_ign_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_func  (in_func),
  .out_valid(out_valid),
  .psel     (psel),
  .pready   (pready)
);

`default_nettype wire

### dv/improved_gradient_noise_3d_tb.sv
// ----------------------------------------------------------------------------
// improved_gradient_noise_3d_tb
// Self-checking bench for the fixed-point 3d/1d gradient noise block. The
// bench fills the permutation table with loads and programs the registers
// through the config port. It then runs directed and random evaluations with
// random request gaps in all but the last phase. Each result is compared
// against an in-bench predictor in request order.
// ----------------------------------------------------------------------------
`default_nettype none

module improved_gradient_noise_3d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ign_pkg::*;

  localparam int FRAC = 16;
  localparam int OCT_MAX = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [FUNC_W-1:0] in_func = FUNC_LOAD;
  logic signed [COORD_W-1:0] in_coord_x = '0;
  logic signed [COORD_W-1:0] in_coord_y = '0;
  logic signed [COORD_W-1:0] in_coord_z = '0;
  logic [TAB_AW-1:0] in_perm_index = '0;
  logic [CELL_W-1:0] in_perm_value = '0;
  logic out_valid;
  logic signed [OUT_W-1:0] out_noise_value;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  improved_gradient_noise_3d dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .in_coord_z(in_coord_z), .in_perm_index(in_perm_index),
    .in_perm_value(in_perm_value), .out_valid(out_valid),
    .out_noise_value(out_noise_value), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [7:0] perm_shadow [TABLE_SIZE];
  cfg_t cfg_shadow;
  logic signed [OUT_W-1:0] expected_noise [$];
  int error_count = 0;
  bit gaps_on = 1'b1;

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  function automatic longint fade(input longint t);
    longint c, d, t2, t3;
    c = (t * (15 * (64'sd1 << FRAC) - 6 * t)) >>> FRAC;
    d = 10 * (64'sd1 << FRAC) - c;
    t2 = (t * t) >>> FRAC;
    t3 = (t2 * t) >>> FRAC;
    return (t3 * d) >>> FRAC;
  endfunction

  function automatic longint lerp(input longint w, input longint a, input longint b);
    return a + ((w * (b - a)) >>> FRAC);
  endfunction

  function automatic longint grad(input int hv, input longint x, input longint y,
                                  input longint z);
    int h;
    longint u, v;
    h = hv & 15;
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (((h & 1) == 0) ? u : -u) + (((h & 2) == 0) ? v : -v);
  endfunction

  function automatic int perm_at(input int i);
    return int'(perm_shadow[i & 255]);
  endfunction

  function automatic longint noise_point(input logic signed [31:0] cx,
                                         input logic signed [31:0] cy,
                                         input logic signed [31:0] cz,
                                         input int sh);
    logic signed [31:0] c [3];
    logic [63:0] p;
    int cidx [3];
    longint f [3];
    longint u, v, w, one, r;
    int a, b, aa, ab, ba, bb;
    c[0] = cx; c[1] = cy; c[2] = cz;
    one = 64'sd1 << FRAC;
    for (int k = 0; k < 3; k++) begin
      p = longint'(c[k]) * longint'({40'd0, cfg_shadow.frequency});
      cidx[k] = int'((p >> (32 + sh)) & 64'hFF);
      f[k] = longint'((p >> (32 + sh - FRAC)) & 64'hFFFF);
    end
    u = fade(f[0]); v = fade(f[1]); w = fade(f[2]);
    a = perm_at(cidx[0]) + cidx[1];
    aa = perm_at(a) + cidx[2];
    ab = perm_at(a + 1) + cidx[2];
    b = perm_at(cidx[0] + 1) + cidx[1];
    ba = perm_at(b) + cidx[2];
    bb = perm_at(b + 1) + cidx[2];
    r = lerp(w,
          lerp(v,
            lerp(u, grad(perm_at(aa), f[0], f[1], f[2]),
                    grad(perm_at(ba), f[0] - one, f[1], f[2])),
            lerp(u, grad(perm_at(ab), f[0], f[1] - one, f[2]),
                    grad(perm_at(bb), f[0] - one, f[1] - one, f[2]))),
          lerp(v,
            lerp(u, grad(perm_at(aa + 1), f[0], f[1], f[2] - one),
                    grad(perm_at(ba + 1), f[0] - one, f[1], f[2] - one)),
            lerp(u, grad(perm_at(ab + 1), f[0], f[1] - one, f[2] - one),
                    grad(perm_at(bb + 1), f[0] - one, f[1] - one, f[2] - one))));
    return (r * longint'({48'd0, cfg_shadow.amplitude})) >>> (FRAC - 8);
  endfunction

  function automatic logic signed [31:0] saturate(input longint s);
    if (s > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  task automatic predict_request(input logic [1:0] fn, input logic signed [31:0] x,
                                 input logic signed [31:0] y,
                                 input logic signed [31:0] z,
                                 input logic [7:0] idx, input logic [7:0] val);
    longint sum;
    int n;
    sum = 0;
    if (fn == FUNC_LOAD) begin
      perm_shadow[idx] = val;
    end else if (fn == FUNC_EVAL3D) begin
      expected_noise.push_back(saturate(noise_point(x, y, z, 0)));
    end else if (fn == FUNC_EVAL1D) begin
      n = (cfg_shadow.octave_count > OCT_MAX) ? OCT_MAX : int'(cfg_shadow.octave_count);
      for (int i = 0; i < n; i++) sum += noise_point(x, 0, 0, i);
      expected_noise.push_back(saturate(sum));
    end
  endtask

  task automatic send_request(input logic [1:0] fn, input logic signed [31:0] x,
                              input logic signed [31:0] y,
                              input logic signed [31:0] z,
                              input logic [7:0] idx, input logic [7:0] val);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    start = 1'b1;
    in_func = fn;
    in_coord_x = x;
    in_coord_y = y;
    in_coord_z = z;
    in_perm_index = idx;
    in_perm_value = val;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_request(fn, x, y, z, idx, val);
  endtask

  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (expected_noise.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] reg_id, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = CFG_AW'(4 * reg_id);
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    case (reg_id)
      REG_FREQUENCY: cfg_shadow.frequency = value[FREQ_W-1:0];
      REG_AMPLITUDE: cfg_shadow.amplitude = value[AMP_W-1:0];
      default: cfg_shadow.octave_count = value[OCT_W-1:0];
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic program_config(input logic [23:0] f, input logic [15:0] a,
                                input logic [3:0] o);
    settle();
    write_register(REG_FREQUENCY, {8'd0, f});
    write_register(REG_AMPLITUDE, {16'd0, a});
    write_register(REG_OCTAVES, {28'd0, o});
  endtask

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
      2: return $signed($urandom_range(0, 32'h0007FFFF)) - 32'sh00040000;
      default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_noise.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", out_noise_value));
      end else begin
        if (out_noise_value !== expected_noise[0])
          report_mismatch($sformatf("noise_value got %0d want %0d",
                                    out_noise_value, expected_noise[0]));
        void'(expected_noise.pop_front());
      end
    end
  end

  task automatic test_table_fill();
    logic [7:0] order [256];
    logic [7:0] tmp;
    int j;
    for (int i = 0; i < 256; i++) order[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    for (int i = 0; i < 256; i++) send_request(FUNC_LOAD, 0, 0, 0, 8'(i), order[i]);
  endtask

  task automatic test_directed();
    logic signed [31:0] pts [6];
    pts = '{32'sh0, 32'sh7FFFFFFF, 32'sh80000000, -32'sd1, 32'sh00018000, 32'sh0000FFFF};
    send_request(2'd3, 32'sh12345678, 1, 2, 8'hFF, 8'hFF);
    send_request(FUNC_LOAD, 0, 0, 0, 8'hFF, 8'hFF);
    send_request(FUNC_LOAD, 0, 0, 0, 8'h00, 8'h00);
    foreach (pts[i]) send_request(FUNC_EVAL3D, pts[i], pts[5 - i], pts[(i + 2) % 6], 0, 0);
    send_request(FUNC_EVAL3D, 32'sh00024000, 32'sh00013000, 0, 0, 0);
    foreach (pts[i]) send_request(FUNC_EVAL1D, pts[i], 0, 0, 0, 0);
  endtask

  task automatic test_register_extremes();
    program_config(24'hFFFFFF, 16'hFFFF, 4'd15);
    send_request(FUNC_EVAL3D, 32'sh7FFFFFFF, 32'sh80000000, 32'sh00008000, 0, 0);
    send_request(FUNC_EVAL1D, 32'sh80000000, 0, 0, 0, 0);
    send_request(FUNC_EVAL1D, 32'sh00035555, 0, 0, 0, 0);
    program_config(24'd0, 16'd0, 4'd0);
    send_request(FUNC_EVAL3D, 32'sh00035555, 32'sh1, 32'sh2, 0, 0);
    send_request(FUNC_EVAL1D, 32'sh00035555, 0, 0, 0, 0);
    program_config(24'h800000, 16'h0100, 4'd8);
    send_request(FUNC_EVAL1D, 32'sh0012_3456, 0, 0, 0, 0);
    program_config(24'h00FFFF, 16'h8000, 4'd9);
    send_request(FUNC_EVAL1D, -32'sh0012_3456, 0, 0, 0, 0);
  endtask

  task automatic test_random(input int count);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 18)
        send_request(FUNC_LOAD, $urandom, $urandom, $urandom, 8'($urandom), 8'($urandom));
      else if (roll < 70)
        send_request(FUNC_EVAL3D, pick_coord(), pick_coord(),
                     ($urandom_range(0, 4) == 0) ? 32'sh0 : pick_coord(),
                     8'($urandom), 8'($urandom));
      else if (roll < 95)
        send_request(FUNC_EVAL1D, pick_coord(), $urandom, $urandom,
                     8'($urandom), 8'($urandom));
      else
        send_request(2'd3, $urandom, $urandom, $urandom, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_random_phases();
    program_config(24'h010000, 16'h0100, 4'd1);
    test_random(400);
    program_config(24'($urandom), 16'($urandom), 4'($urandom_range(0, 3)));
    test_random(400);
    program_config(24'h000400, 16'hFFFF, 4'd2);
    test_random(300);
    program_config(24'($urandom_range(0, 24'h0FFFFF)), 16'($urandom), 4'd1);
    test_random(300);
    gaps_on = 1'b0;
    program_config(24'h028000, 16'h0180, 4'd3);
    test_random(400);
  endtask

  initial begin
    cfg_shadow.frequency = FREQ_RESET;
    cfg_shadow.amplitude = AMP_RESET;
    cfg_shadow.octave_count = OCT_RESET;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_table_fill();
    test_directed();
    test_register_extremes();
    test_random_phases();
    settle();
    repeat (500) @(negedge clk);
    if (error_count == 0 && expected_noise.size() == 0) begin
      $display("[improved_gradient_noise_3d] OK");
    end else begin
      $display("[improved_gradient_noise_3d] ERROR");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("[improved_gradient_noise_3d] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
